FILE: hdl/c8080_pkg.sv
// Package for the 8080 subset executor: widths, command codes, states, helpers.
// No dependencies.
`default_nettype none
package c8080_pkg;
    localparam int MemDepth = 65536;
    localparam int MemAw    = $clog2(MemDepth);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXEC  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_OP    = 7'b0000010,
        ST_B1    = 7'b0000100,
        ST_B2    = 7'b0001000,
        ST_EXEC  = 7'b0010000,
        ST_DATA  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    localparam logic [2:0] FL_Z  = 3'd0;
    localparam logic [2:0] FL_S  = 3'd1;
    localparam logic [2:0] FL_P  = 3'd2;
    localparam logic [2:0] FL_CY = 3'd3;
    localparam logic [2:0] FL_AC = 3'd4;

    function automatic logic op_halts(input logic [7:0] op);
        logic h;
        h = 1'b0;
        if (op == 8'h17 || op == 8'h1F || op == 8'h20 || op == 8'h22 ||
            op == 8'h27 || op == 8'h2A || op == 8'h2F || op == 8'h3F)
            h = 1'b1;
        if (op >= 8'h30 && op <= 8'h37) h = 1'b1;
        if (op >= 8'h39 && op <= 8'h3B) h = 1'b1;
        if (op >= 8'h40)
            h = !(op == 8'hCB || op == 8'hD9 || op == 8'hDD || op == 8'hED);
        return h;
    endfunction

    function automatic logic [4:0] zsp(input logic [7:0] v);
        logic [4:0] f;
        f = '0;
        f[FL_Z] = (v == 8'd0);
        f[FL_S] = v[7];
        f[FL_P] = ~^v;
        return f;
    endfunction

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] pc_after;
        logic [7:0]  accumulator_out;
        logic [4:0]  flags_out;
        logic        status;
    } result_t;
endpackage
`default_nettype wire

FILE: hdl/c8080_ram.sv
// Single-port byte memory with registered read.
// Depends on c8080_pkg.
`default_nettype none
module c8080_ram
    import c8080_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [MemAw-1:0] addr,
    input  wire logic [7:0]       wdata,
    output logic      [7:0]       rdata
);
    logic [7:0] mem [MemDepth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: hdl/cpu8080_subset_executor_top.sv
// Top level of the 8080 subset executor: sequencer, register file, byte memory.
// Depends on c8080_pkg and c8080_ram.
//
//  channel | dir | tdata fields (low bit up)
//  s_      | in  | command[1:0] address[17:2] data[25:18], pad to 32
//  m_      | out | read_data[7:0] pc_after[23:8] acc[31:24] flags[36:32] status[37], pad 40
//
// Steps from the moment a command is taken: an execute reads the opcode and two
// immediates on one memory port, then executes and forms the result; LDAX adds one
// more data read. A read does one data read; a write or an execute while halted goes
// straight to the result. One command at a time; the next is taken once the result
// register is free. A stalled result holds until taken.
// Reset clears registers, pc, flags and halt; memory content is not cleared.
`default_nettype none
module cpu8080_subset_executor_top
    import c8080_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // command, address, data
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata   // read_data, pc_after, accumulator_out, flags_out, status
);
    state_t      state_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  op_reg, b1_reg;
    logic [7:0]  acc_reg;
    logic [7:0]  gr_reg [6];
    logic [15:0] pc_reg;
    logic [4:0]  fl_reg;
    logic        halt_reg;
    result_t     res_reg;
    logic        mv_out_reg;

    logic             mem_we;
    logic [MemAw-1:0] mem_addr;
    logic [7:0]       mem_wdata, mem_rdata;

    c8080_ram u_ram (
        .aclk (aclk), .we (mem_we), .addr (mem_addr),
        .wdata(mem_wdata), .rdata(mem_rdata)
    );

    logic [1:0]  rp;
    logic [2:0]  hi_idx, lo_idx, ddd;
    logic [15:0] pair_v, hl_v;
    logic        is_lxi, is_mvi, is_stax, is_ldax;

    always_comb begin
        rp     = op_reg[5:4];
        ddd    = op_reg[5:3];
        hi_idx = (rp == 2'd3) ? 3'd4 : {rp, 1'b0};
        lo_idx = hi_idx + 3'd1;
        pair_v = {gr_reg[hi_idx], gr_reg[lo_idx]};
        hl_v   = {gr_reg[4], gr_reg[5]};
        is_lxi = (op_reg == 8'h01 || op_reg == 8'h11 || op_reg == 8'h21);
        is_mvi = (op_reg[2:0] == 3'b110) && (op_reg[7:6] == 2'b00) && (ddd != 3'd6);
        is_stax = (op_reg == 8'h02 || op_reg == 8'h12);
        is_ldax = (op_reg == 8'h0A || op_reg == 8'h1A);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = addr_reg[MemAw-1:0];
        mem_wdata = data_reg;
        unique case (state_reg)
            ST_IDLE: ;
            ST_OP:   mem_addr = pc_reg[MemAw-1:0];
            ST_B1:   mem_addr = MemAw'(pc_reg + 16'd1);
            ST_B2:   mem_addr = MemAw'(pc_reg + 16'd2);
            ST_EXEC: begin
                mem_addr  = pair_v[MemAw-1:0];
                mem_wdata = acc_reg;
                mem_we    = is_stax;
            end
            ST_DATA: ;
            ST_DONE: mem_we = (cmd_reg == CMD_WRITE);
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !mv_out_reg && aresetn;

    logic [7:0]  r_old, r_new;
    logic [4:0]  fl_inr;
    logic [16:0] dsum;
    always_comb begin
        r_old = (ddd == 3'd7) ? acc_reg : gr_reg[ddd];
        r_new = op_reg[0] ? 8'(r_old - 8'd1) : 8'(r_old + 8'd1);
        fl_inr         = zsp(r_new);
        fl_inr[FL_CY]  = fl_reg[FL_CY];
        fl_inr[FL_AC]  = op_reg[0] ? (r_old[3:0] != 4'h0) : (r_old[3:0] == 4'hF);
        dsum  = {1'b0, hl_v} + {1'b0, pair_v};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_NONE;
            acc_reg   <= '0;
            for (int i = 0; i < 6; i++) gr_reg[i] <= '0;
            pc_reg    <= '0;
            fl_reg    <= '0;
            halt_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg  <= s_tdata[1:0];
                        addr_reg <= s_tdata[17:2];
                        data_reg <= s_tdata[25:18];
                        if (s_tdata[1:0] == CMD_EXEC && !halt_reg) state_reg <= ST_OP;
                        else if (s_tdata[1:0] == CMD_READ) state_reg <= ST_DATA;
                        else state_reg <= ST_DONE;
                    end
                end
                ST_OP: state_reg <= ST_B1;
                ST_B1: begin
                    op_reg    <= mem_rdata;
                    state_reg <= ST_B2;
                end
                ST_B2: begin
                    b1_reg    <= mem_rdata;
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    state_reg <= ST_DONE;
                    if (op_halts(op_reg)) begin
                        halt_reg <= 1'b1;
                    end else begin
                        pc_reg <= 16'(pc_reg + (is_lxi ? 16'd3 : is_mvi ? 16'd2 : 16'd1));
                        if (is_lxi) begin
                            gr_reg[hi_idx] <= mem_rdata;
                            gr_reg[lo_idx] <= b1_reg;
                        end else if (is_ldax) begin
                            state_reg <= ST_DATA;
                        end else if (is_mvi) begin
                            if (ddd == 3'd7) acc_reg <= b1_reg;
                            else gr_reg[ddd] <= b1_reg;
                        end else if (op_reg[7:6] == 2'b00 && op_reg[2:1] == 2'b10
                                     && ddd != 3'd6) begin
                            if (ddd == 3'd7) acc_reg <= r_new;
                            else gr_reg[ddd] <= r_new;
                            fl_reg <= fl_inr;
                        end else if (op_reg == 8'h03 || op_reg == 8'h13 || op_reg == 8'h23
                                     || op_reg == 8'h0B || op_reg == 8'h1B
                                     || op_reg == 8'h2B) begin
                            {gr_reg[hi_idx], gr_reg[lo_idx]} <= op_reg[3]
                                ? 16'(pair_v - 16'd1) : 16'(pair_v + 16'd1);
                        end else if (op_reg == 8'h07) begin
                            acc_reg <= {acc_reg[6:0], acc_reg[7]};
                            fl_reg[FL_CY] <= acc_reg[7];
                        end else if (op_reg == 8'h0F) begin
                            acc_reg <= {acc_reg[0], acc_reg[7:1]};
                            fl_reg[FL_CY] <= acc_reg[0];
                        end else if (op_reg == 8'h09 || op_reg == 8'h19 || op_reg == 8'h29) begin
                            gr_reg[4] <= dsum[15:8];
                            gr_reg[5] <= dsum[7:0];
                            fl_reg[FL_CY] <= dsum[16];
                        end
                    end
                end
                ST_DATA: begin
                    // ldax data arrives in the cycle after its address
                    if (cmd_reg == CMD_EXEC) acc_reg <= mem_rdata;
                    state_reg <= ST_DONE;
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE) begin
            res_reg.read_data       <= (cmd_reg == CMD_READ) ? mem_rdata : 8'd0;
            res_reg.pc_after        <= pc_reg;
            res_reg.accumulator_out <= acc_reg;
            res_reg.flags_out       <= fl_reg;
            res_reg.status          <= halt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_out_reg <= 1'b0;
        end else if (state_reg == ST_DONE) begin
            mv_out_reg <= 1'b1;
        end else if (m_tready) begin
            mv_out_reg <= 1'b0;
        end
    end

    assign m_tvalid = mv_out_reg;
    assign m_tdata  = {2'b00, res_reg.status, res_reg.flags_out,
                       res_reg.accumulator_out, res_reg.pc_after, res_reg.read_data};
endmodule
`default_nettype wire
